// ===== src/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and codes for the priority sorted table: the stored entry,
// operation and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package pst_pkg;

	localparam int HANDLE_W = 16;
	localparam int PRIO_W   = 15;
	localparam int POS_W    = 6;
	localparam int COUNT_W  = 7;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [PRIO_W-1:0]   prio;
	} entry_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REPRIO = 2'd1,
		OP_REMOVE = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_NOT_OCC = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_SCAN,
		S_FINAL
	} seq_state_t;

endpackage

// ===== src/pst_mem.sv =====
// ----------------------------------------------------------------------------
// pst_mem
// Entry storage: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pst_mem
	import pst_pkg::*;
#(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/pst_seq.sv =====
// ----------------------------------------------------------------------------
// pst_seq
// Operation sequencer: fetches the addressed entry, walks neighbors one per
// cycle while shifting them by one slot, writes the moved entry and drives
// the result beat.
// ----------------------------------------------------------------------------
module pst_seq
	import pst_pkg::*;
#(
	parameter int CAPACITY = 64,
	localparam int AW = $clog2(CAPACITY)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          op,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [PRIO_W-1:0]   priority_req,
	input  logic [POS_W-1:0]    position,
	output logic                busy,
	output logic                done,
	output logic [1:0]          status,
	output logic [POS_W-1:0]    entry_position,
	output logic [HANDLE_W-1:0] entry_handle,
	output logic [PRIO_W-1:0]   entry_priority,
	output logic [COUNT_W-1:0]  entry_count,
	output logic                mem_we,
	output logic [AW-1:0]       mem_waddr,
	output entry_t              mem_wdata,
	output logic                mem_re,
	output logic [AW-1:0]       mem_raddr,
	input  entry_t              mem_rdata
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = CW + POS_W;
	localparam int PXW = AW + POS_W;
	localparam int CXW = CW + COUNT_W;

	seq_state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic done_q;

	op_t op_q;
	entry_t mover_q, removed_q;
	logic [PRIO_W-1:0] prio_q;
	logic [AW-1:0] pos_q, j_q, dst_q;
	logic down_q;
	logic [1:0] status_q;
	logic [POS_W-1:0] epos_q;
	logic [HANDLE_W-1:0] ehandle_q;
	logic [PRIO_W-1:0] eprio_q;
	logic [COUNT_W-1:0] ecount_q;

	op_t op_in;
	logic accept, full, pos_bad, is_insert;
	logic [XW-1:0] pos_x, cnt_x;
	logic [AW-1:0] pos_a, j_inc, j_dec, pos_inc_a, pos_dec_a;
	logic [CW-1:0] cnt_dec, pos_inc, j_next_cnt, cnt_new;
	logic pos_last, j_last, fetch_up, fetch_dn, fetch_scan, shift, scan_end;
	logic reject, emit_final;
	logic [PXW-1:0] dst_out_x, pos_out_x;
	logic [CXW-1:0] cnt_out_x, cnt_new_x;

	assign op_in     = op_t'(op);
	assign accept    = start && (state_q == S_IDLE);
	assign is_insert = (op_in == OP_INSERT);
	assign full      = (cnt_q == CW'(CAPACITY));
	assign pos_x     = XW'(position);
	assign cnt_x     = XW'(cnt_q);
	assign pos_bad   = (pos_x >= cnt_x);
	// position is below the count here, so it fits the address width
	assign pos_a     = pos_x[AW-1:0];
	assign cnt_dec   = cnt_q - CW'(1);

	assign pos_inc    = CW'(pos_q) + CW'(1);
	assign pos_last   = (pos_inc == cnt_q);
	assign pos_inc_a  = pos_q + AW'(1);
	assign pos_dec_a  = pos_q - AW'(1);
	assign j_inc      = j_q + AW'(1);
	assign j_dec      = j_q - AW'(1);
	assign j_next_cnt = CW'(j_q) + CW'(1);
	assign j_last     = (j_next_cnt == cnt_q);

	// remove walks up and shifts everything after the gap
	assign fetch_up   = (op_q == OP_REMOVE) || ((op_q == OP_REPRIO) && (prio_q > mem_rdata.prio));
	assign fetch_dn   = (op_q == OP_REPRIO) && (prio_q < mem_rdata.prio);
	assign fetch_scan = (fetch_up && !pos_last) || (fetch_dn && (pos_q != '0));

	assign shift    = down_q ? (prio_q < mem_rdata.prio)
	                         : ((op_q == OP_REMOVE) || (prio_q > mem_rdata.prio));
	assign scan_end = down_q ? (j_q == '0) : j_last;

	assign reject     = accept && (is_insert ? full : pos_bad);
	assign emit_final = (state_q == S_FINAL);

	always_comb begin
		unique case (op_q)
			OP_INSERT: cnt_new = cnt_q + CW'(1);
			OP_REMOVE: cnt_new = cnt_q - CW'(1);
			default:   cnt_new = cnt_q;
		endcase
	end

	assign dst_out_x = PXW'(dst_q);
	assign pos_out_x = PXW'(pos_q);
	assign cnt_out_x = CXW'(cnt_q);
	assign cnt_new_x = CXW'(cnt_new);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (reject) begin
						state_d = S_IDLE;
					end else if (is_insert) begin
						state_d = (cnt_q == '0) ? S_FINAL : S_SCAN;
					end else begin
						state_d = S_FETCH;
					end
				end
			end
			S_FETCH: begin
				if (op_q == OP_READ) begin
					state_d = S_IDLE;
				end else begin
					state_d = fetch_scan ? S_SCAN : S_FINAL;
				end
			end
			S_SCAN: begin
				state_d = (shift && !scan_end) ? S_SCAN : S_FINAL;
			end
			S_FINAL: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory port control; a shift writes behind the walk, so a write never
	// hits an entry that is still to be read
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = mem_rdata;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !reject) begin
					if (is_insert) begin
						mem_re    = (cnt_q != '0);
						mem_raddr = cnt_dec[AW-1:0];
					end else begin
						mem_re    = 1'b1;
						mem_raddr = pos_a;
					end
				end
			end
			S_FETCH: begin
				if (op_q != OP_READ) begin
					mem_re    = fetch_scan;
					mem_raddr = fetch_up ? pos_inc_a : pos_dec_a;
				end
			end
			S_SCAN: begin
				mem_re    = shift && !scan_end;
				mem_raddr = down_q ? j_dec : j_inc;
				mem_we    = shift;
				mem_waddr = down_q ? j_inc : j_dec;
				mem_wdata = mem_rdata;
			end
			S_FINAL: begin
				mem_we    = 1'b1;
				mem_waddr = dst_q;
				mem_wdata = mover_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= reject || ((state_q == S_FETCH) && (op_q == OP_READ)) || emit_final;
			if (emit_final) begin
				cnt_q <= cnt_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q    <= op_in;
					prio_q  <= priority_req;
					mover_q <= '{handle: handle, prio: priority_req};
					pos_q   <= pos_a;
					j_q     <= cnt_dec[AW-1:0];
					down_q  <= 1'b1;
					dst_q   <= '0;
				end
				if (reject) begin
					status_q  <= is_insert ? STAT_FULL : STAT_NOT_OCC;
					epos_q    <= '0;
					ehandle_q <= '0;
					eprio_q   <= '0;
					ecount_q  <= cnt_out_x[COUNT_W-1:0];
				end
			end
			S_FETCH: begin
				removed_q <= mem_rdata;
				mover_q   <= (op_q == OP_REMOVE) ? entry_t'('0)
				                                 : entry_t'{handle: mem_rdata.handle, prio: prio_q};
				down_q    <= fetch_dn;
				j_q       <= fetch_up ? pos_inc_a : pos_dec_a;
				dst_q     <= pos_q;
				if (op_q == OP_READ) begin
					status_q  <= STAT_DONE;
					epos_q    <= pos_out_x[POS_W-1:0];
					ehandle_q <= mem_rdata.handle;
					eprio_q   <= mem_rdata.prio;
					ecount_q  <= cnt_out_x[COUNT_W-1:0];
				end
			end
			S_SCAN: begin
				j_q   <= down_q ? j_dec : j_inc;
				// stop on a kept neighbor: the mover lands next to it
				dst_q <= shift ? j_q : (down_q ? j_inc : j_dec);
			end
			S_FINAL: begin
				status_q <= STAT_DONE;
				ecount_q <= cnt_new_x[COUNT_W-1:0];
				if (op_q == OP_REMOVE) begin
					epos_q    <= pos_out_x[POS_W-1:0];
					ehandle_q <= removed_q.handle;
					eprio_q   <= removed_q.prio;
				end else begin
					epos_q    <= dst_out_x[POS_W-1:0];
					ehandle_q <= mover_q.handle;
					eprio_q   <= mover_q.prio;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign status         = status_q;
	assign entry_position = epos_q;
	assign entry_handle   = ehandle_q;
	assign entry_priority = eprio_q;
	assign entry_count    = ecount_q;

endmodule

// ===== src/priority_sorted_table.sv =====
// ----------------------------------------------------------------------------
// priority_sorted_table
// Table of handle/priority pairs kept in ascending priority order.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to issue one operation: insert, reprioritize,
// remove or read. Exactly one result beat follows on done, one cycle wide,
// and it cannot be held off, so capture it when done is high. The table lives
// in a single memory with one read and one write port, and neighbors move one
// slot per cycle through it. A rejected operation (full table, position not
// occupied) gives its beat in the cycle after start and does not raise busy;
// a read passes through the fetch state only. An insert scans down from the
// last entry, shifting each entry of greater priority up one slot, and writes
// itself in the final state. A reprioritize or remove fetches its entry,
// shifts neighbors one slot as the new priority or the gap calls for, and
// ends in the final state. When busy was raised, the result beat shows in
// the first cycle with busy low. After reset the count is zero; slots beyond
// the count are never read, so no clearing pass is needed and the block
// accepts work right away.
module priority_sorted_table
	import pst_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          op,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [PRIO_W-1:0]   priority_req,
	input  logic [POS_W-1:0]    position,
	output logic                busy,
	output logic                done,
	output logic [1:0]          status,
	output logic [POS_W-1:0]    entry_position,
	output logic [HANDLE_W-1:0] entry_handle,
	output logic [PRIO_W-1:0]   entry_priority,
	output logic [COUNT_W-1:0]  entry_count
);

	localparam int AW = $clog2(CAPACITY);

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	entry_t        mem_wdata, mem_rdata;

	pst_mem #(
		.DEPTH(CAPACITY)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	pst_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.op            (op),
		.handle        (handle),
		.priority_req  (priority_req),
		.position      (position),
		.busy          (busy),
		.done          (done),
		.status        (status),
		.entry_position(entry_position),
		.entry_handle  (entry_handle),
		.entry_priority(entry_priority),
		.entry_count   (entry_count),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata)
	);

endmodule
